### design/assert_macros.svh
// Assertion macros for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LJE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LJE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LJE_ASSERT(lbl, prop, msg)
`define LJE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### design/lje_pkg.sv
// Types, constants and saturation helper for the pair energy and gradient block.
package lje_pkg;

  localparam int MAX_ATOMS_DEF = 8;

  localparam logic [46:0] QMAX47   = 47'h7FFF_FFFF_FFFF;
  localparam logic [47:0] Q_SIX    = 48'h0000_0600_0000;
  localparam logic [47:0] Q_TWELVE = 48'h0000_0C00_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               final_atom;
  } in_t;

  typedef struct packed {
    logic        [2:0]  atom_index;
    logic signed [47:0] grad_x;
    logic signed [47:0] grad_y;
    logic signed [47:0] energy;
    logic               saturated;
    logic               run_end;
  } out_t;

  typedef struct packed {
    logic               flag;
    logic signed [47:0] val;
  } sat48_t;

  function automatic sat48_t sat48(input logic [49:0] v);
    sat48_t r;
    if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
      r.flag = 1'b0;
      r.val  = v[47:0];
    end else begin
      r.flag = 1'b1;
      r.val  = v[49] ? {1'b1, 47'd0} : {1'b0, QMAX47};
    end
    return r;
  endfunction

endpackage

### design/lje_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lje_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/lennard_jones_energy_gradient.sv
// Top level: 2-D Lennard-Jones pair energy and per-atom gradient engine.
//
//  channel | direction | payload | transaction
//  in_     | input     | in_t    | one atom, final_atom closes the set
//  out_    | output    | out_t   | one gradient per stored atom, energy on last
//
// Loading accepts one atom per cycle. Each pair runs eleven products on one shared
// 24x24 multiplier and a restoring reciprocal, which is skipped at zero distance.
// Results follow a flag pass over the gradient RAM, then leave one at a time, each
// read from the RAM only after the previous result is accepted.
// Reset is synchronous; the input stalls from final_atom until the last result leaves.
`include "assert_macros.svh"
module lennard_jones_energy_gradient import lje_pkg::*; #(
  parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = $clog2(MAX_ATOMS);
  localparam int CW = $clog2(MAX_ATOMS + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_RDK, S_CAPK, S_RDJ, S_CAPJ, S_MUL, S_MRES,
    S_DIV, S_UPD, S_WRK, S_GRD, S_GCAP, S_OWAIT
  } state_t;

  typedef enum logic [3:0] {
    ST_SX, ST_D2, ST_R4, ST_R6, ST_R8, ST_R12, ST_R14, ST_P6, ST_P12, ST_AX, ST_AY
  } step_t;

  state_t state_r;
  step_t  step_r;
  logic [CW-1:0] cnt_r, n_r, cnt_inc;
  logic [AW-1:0] k_r, j_r, o_r;
  logic pass_r, err_r, out_valid_r;
  logic [1:0] mc_r;
  logic [5:0] dc_r;
  out_t out_r;

  logic signed [31:0] pkx_r, pky_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [47:0] gkx_r, gky_r, gjx_r, gjy_r, energy_r, c_r, ax_r, ay_r;
  logic [95:0] acc_r, acc_nxt, pp_sh;
  logic [48:0] sx_r;
  logic [49:0] d2_r, d2_nxt, rem_r, rem_nxt;
  logic [56:0] q_r, q_nxt;
  logic [50:0] div_trial;
  logic div_ge;
  logic [46:0] inv2_r, r4_r, r6_r, r8_r, r12_r, r14_r, p6_r, um;
  logic um_sat;
  logic [47:0] ma, mb, c_mag, a_h48, b_h48;
  logic [23:0] a_h, b_h;
  logic [47:0] pp;
  logic [32:0] adx, ady;
  logic [47:0] um_sgn;

  logic pos_we, grad_we;
  logic [AW-1:0] pos_raddr, grad_raddr, grad_waddr;
  logic [63:0] pos_rdata;
  logic [95:0] grad_rdata, grad_wdata;
  logic signed [47:0] rgx, rgy;

  sat48_t s_gkx, s_gky, s_gjx, s_gjy, s_c, s_e, s_sx, s_sy, s_e4;

  logic in_fire, out_fire, j_last, k_last, o_last;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;

  assign cnt_inc = (cnt_r != CW'(MAX_ATOMS)) ? cnt_r + 1'b1 : cnt_r;
  assign j_last  = (j_r == k_r - 1'b1);
  assign k_last  = (CW'(k_r) == n_r - 1'b1);
  assign o_last  = (CW'(o_r) == n_r - 1'b1);

  assign pos_we     = in_fire && (cnt_r != CW'(MAX_ATOMS));
  assign pos_raddr  = (state_r == S_RDK) ? k_r : j_r;
  assign grad_raddr = (state_r == S_GRD) ? o_r : j_r;

  lje_ram #(.WIDTH(64), .DEPTH(MAX_ATOMS)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_data.pos_x, in_data.pos_y}),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  lje_ram #(.WIDTH(96), .DEPTH(MAX_ATOMS)) u_grad_ram (
    .clk   (clk),
    .we    (grad_we),
    .waddr (grad_waddr),
    .wdata (grad_wdata),
    .raddr (grad_raddr),
    .rdata (grad_rdata)
  );

  assign adx   = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign ady   = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign c_mag = c_r[47] ? 48'(-c_r) : 48'(c_r);

  always_comb begin
    case (step_r)
      ST_SX:   begin ma = 48'(adx);    mb = 48'(adx);    end
      ST_D2:   begin ma = 48'(ady);    mb = 48'(ady);    end
      ST_R4:   begin ma = 48'(inv2_r); mb = 48'(inv2_r); end
      ST_R6:   begin ma = 48'(r4_r);   mb = 48'(inv2_r); end
      ST_R8:   begin ma = 48'(r4_r);   mb = 48'(r4_r);   end
      ST_R12:  begin ma = 48'(r6_r);   mb = 48'(r6_r);   end
      ST_R14:  begin ma = 48'(r6_r);   mb = 48'(r8_r);   end
      ST_P6:   begin ma = Q_SIX;       mb = 48'(r8_r);   end
      ST_P12:  begin ma = Q_TWELVE;    mb = 48'(r14_r);  end
      ST_AX:   begin ma = c_mag;       mb = 48'(adx);    end
      ST_AY:   begin ma = c_mag;       mb = 48'(ady);    end
      default: begin ma = '0;          mb = '0;          end
    endcase
  end

  assign a_h   = mc_r[1] ? ma[47:24] : ma[23:0];
  assign b_h   = mc_r[0] ? mb[47:24] : mb[23:0];
  assign a_h48 = 48'(a_h);
  assign b_h48 = 48'(b_h);
  assign pp    = a_h48 * b_h48;

  always_comb begin
    case (mc_r)
      2'd0:    pp_sh = 96'(pp);
      2'd3:    pp_sh = 96'(pp) << 48;
      default: pp_sh = 96'(pp) << 24;
    endcase
  end

  assign acc_nxt = ((mc_r == 2'd0) ? 96'd0 : acc_r) + pp_sh;
  assign um_sat  = |acc_r[95:71];
  assign um      = um_sat ? QMAX47 : acc_r[70:24];
  assign um_sgn  = ((c_r[47] ^ ((step_r == ST_AX) ? dx_r[32] : dy_r[32])) ?
                    48'(-{1'b0, um}) : 48'({1'b0, um}));

  assign d2_nxt    = {1'b0, sx_r} + {1'b0, acc_r[64:16]};
  assign div_trial = {rem_r, dc_r == 6'd56};
  assign div_ge    = div_trial >= {1'b0, d2_r};
  assign rem_nxt   = div_ge ? 50'(div_trial - {1'b0, d2_r}) : div_trial[49:0];
  assign q_nxt     = {q_r[55:0], div_ge};

  assign s_c  = sat48(50'(p6_r) - 50'(um));
  assign s_e  = sat48(50'(energy_r) + 50'(r12_r) - 50'(r6_r));
  assign s_gkx = sat48(50'(gkx_r) + 50'(ax_r));
  assign s_gky = sat48(50'(gky_r) + 50'(ay_r));
  assign s_gjx = sat48(50'(gjx_r) - 50'(ax_r));
  assign s_gjy = sat48(50'(gjy_r) - 50'(ay_r));

  assign rgx  = (n_r == CW'(1)) ? 48'sd0 : grad_rdata[95:48];
  assign rgy  = (n_r == CW'(1)) ? 48'sd0 : grad_rdata[47:0];
  assign s_sx = sat48({rgx, 2'b00});
  assign s_sy = sat48({rgy, 2'b00});
  assign s_e4 = sat48({energy_r, 2'b00});

  assign grad_we    = (state_r == S_UPD) || (state_r == S_WRK);
  assign grad_waddr = (state_r == S_WRK) ? k_r : j_r;
  assign grad_wdata = (state_r == S_WRK) ? {gkx_r, gky_r} : {s_gjx.val, s_gjy.val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
      mc_r        <= '0;
      step_r      <= ST_SX;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            cnt_r <= cnt_inc;
            if (cnt_r == CW'(MAX_ATOMS)) begin
              err_r <= 1'b1;
            end
            if (in_data.final_atom) begin
              n_r      <= cnt_inc;
              energy_r <= '0;
              k_r      <= AW'(1);
              o_r      <= '0;
              pass_r   <= 1'b0;
              state_r  <= (cnt_inc >= CW'(2)) ? S_RDK : S_GRD;
            end
          end
        end
        S_RDK: state_r <= S_CAPK;
        S_CAPK: begin
          pkx_r   <= pos_rdata[63:32];
          pky_r   <= pos_rdata[31:0];
          gkx_r   <= '0;
          gky_r   <= '0;
          j_r     <= '0;
          state_r <= S_RDJ;
        end
        S_RDJ: state_r <= S_CAPJ;
        S_CAPJ: begin
          dx_r    <= 33'(pkx_r) - 33'($signed(pos_rdata[63:32]));
          dy_r    <= 33'(pky_r) - 33'($signed(pos_rdata[31:0]));
          gjx_r   <= (k_r == AW'(1)) ? 48'sd0 : grad_rdata[95:48];
          gjy_r   <= (k_r == AW'(1)) ? 48'sd0 : grad_rdata[47:0];
          step_r  <= ST_SX;
          mc_r    <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r <= acc_nxt;
          mc_r  <= mc_r + 1'b1;
          if (mc_r == 2'd3) begin
            state_r <= S_MRES;
          end
        end
        S_MRES: begin
          state_r <= S_MUL;
          case (step_r)
            ST_SX: begin
              sx_r   <= acc_r[64:16];
              step_r <= ST_D2;
            end
            ST_D2: begin
              d2_r <= d2_nxt;
              if (d2_nxt == '0) begin
                inv2_r <= QMAX47;
                err_r  <= 1'b1;
                step_r <= ST_R4;
              end else begin
                rem_r   <= '0;
                q_r     <= '0;
                dc_r    <= 6'd56;
                state_r <= S_DIV;
              end
            end
            ST_R4:  begin r4_r  <= um; err_r <= err_r | um_sat; step_r <= ST_R6;  end
            ST_R6:  begin r6_r  <= um; err_r <= err_r | um_sat; step_r <= ST_R8;  end
            ST_R8:  begin r8_r  <= um; err_r <= err_r | um_sat; step_r <= ST_R12; end
            ST_R12: begin r12_r <= um; err_r <= err_r | um_sat; step_r <= ST_R14; end
            ST_R14: begin r14_r <= um; err_r <= err_r | um_sat; step_r <= ST_P6;  end
            ST_P6:  begin p6_r  <= um; err_r <= err_r | um_sat; step_r <= ST_P12; end
            ST_P12: begin
              c_r      <= s_c.val;
              energy_r <= s_e.val;
              err_r    <= err_r | um_sat | s_c.flag | s_e.flag;
              step_r   <= ST_AX;
            end
            ST_AX: begin
              ax_r   <= um_sgn;
              err_r  <= err_r | um_sat;
              step_r <= ST_AY;
            end
            ST_AY: begin
              ay_r    <= um_sgn;
              err_r   <= err_r | um_sat;
              state_r <= S_UPD;
            end
            default: state_r <= S_UPD;
          endcase
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          dc_r  <= dc_r - 1'b1;
          if (dc_r == 6'd0) begin
            if (|q_nxt[56:47]) begin
              inv2_r <= QMAX47;
              err_r  <= 1'b1;
            end else begin
              inv2_r <= q_nxt[46:0];
            end
            step_r  <= ST_R4;
            mc_r    <= '0;
            state_r <= S_MUL;
          end
        end
        S_UPD: begin
          gkx_r <= s_gkx.val;
          gky_r <= s_gky.val;
          err_r <= err_r | s_gkx.flag | s_gky.flag | s_gjx.flag | s_gjy.flag;
          if (j_last) begin
            state_r <= S_WRK;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_RDJ;
          end
        end
        S_WRK: begin
          if (k_last) begin
            o_r     <= '0;
            pass_r  <= 1'b0;
            state_r <= S_GRD;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_RDK;
          end
        end
        S_GRD: state_r <= S_GCAP;
        S_GCAP: begin
          if (!pass_r) begin
            err_r <= err_r | s_sx.flag | s_sy.flag | (o_last & s_e4.flag);
            if (o_last) begin
              o_r    <= '0;
              pass_r <= 1'b1;
            end else begin
              o_r <= o_r + 1'b1;
            end
            state_r <= S_GRD;
          end else begin
            out_r.atom_index <= 3'(o_r);
            out_r.grad_x     <= s_sx.val;
            out_r.grad_y     <= s_sy.val;
            out_r.energy     <= o_last ? s_e4.val : 48'sd0;
            out_r.saturated  <= err_r;
            out_r.run_end    <= o_last;
            out_valid_r      <= 1'b1;
            state_r          <= S_OWAIT;
          end
        end
        S_OWAIT: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
            if (out_r.run_end) begin
              cnt_r   <= '0;
              err_r   <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              o_r     <= o_r + 1'b1;
              state_r <= S_GRD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  `LJE_ASSERT(a_no_overlap, !(in_ready && out_valid), "input open while a result is pending")
  `LJE_ASSERT(a_mid_set_closed, out_fire && !out_data.run_end |=> !in_ready, "input reopened mid set")
  `LJE_ASSERT(a_end_reopens, out_fire && out_data.run_end |=> in_ready, "input not reopened after set")
  `LJE_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid, "result valid after reset")

endmodule

### verif/lennard_jones_energy_gradient_test.sv
// Testbench for the Lennard-Jones pair energy and gradient engine.
module lennard_jones_energy_gradient_test import lje_pkg::*; ();

  localparam longint QMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint QMIN = -QMAX - 1;
  localparam int NATOMS = MAX_ATOMS_DEF;
  localparam logic [31:0] ONE = 32'h0100_0000;
  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PMIN = 32'h8000_0000;

  typedef struct {
    in_t atom;
    bit  typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  longint xs[NATOMS];
  longint ys[NATOMS];
  longint gx[NATOMS];
  longint gy[NATOMS];
  longint energy_sum;
  int     n_stored = 0;
  bit     sat_seen = 1'b0;

  out_t gradient_q[$];
  int   errors = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  bit   hold_off = 1'b0;
  int   items_sent = 0;

  stim_row_t directed_rows[17];

  lennard_jones_energy_gradient dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned mulq(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> 24;
    if (p > QMAX) begin
      sat_seen = 1'b1;
      return QMAX;
    end
    return p[63:0];
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint smulq(longint a, longint b);
    longint m;
    m = mulq(magn(a), magn(b));
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > QMAX) begin
      sat_seen = 1'b1;
      return QMAX;
    end
    if (v < QMIN) begin
      sat_seen = 1'b1;
      return QMIN;
    end
    return v;
  endfunction

  function automatic void pair_force(int k, int j);
    longint dx, dy, c, ax, ay;
    longint unsigned adx, ady, d2, inv2, r4, r6, r8, r12, r14;
    dx = xs[k] - xs[j];
    dy = ys[k] - ys[j];
    adx = magn(dx);
    ady = magn(dy);
    d2 = ((adx * adx) >> 16) + ((ady * ady) >> 16);
    if (d2 == 0) begin
      inv2 = QMAX;
      sat_seen = 1'b1;
    end else begin
      inv2 = (64'd1 << 56) / d2;
      if (inv2 > QMAX) begin
        inv2 = QMAX;
        sat_seen = 1'b1;
      end
    end
    r4 = mulq(inv2, inv2);
    r6 = mulq(r4, inv2);
    r8 = mulq(r4, r4);
    r12 = mulq(r6, r6);
    r14 = mulq(r6, r8);
    energy_sum = clamp48(energy_sum + (longint'(r12) - longint'(r6)));
    c = clamp48(longint'(mulq(Q_SIX, r8)) - longint'(mulq(Q_TWELVE, r14)));
    ax = smulq(c, dx);
    ay = smulq(c, dy);
    gx[k] = clamp48(gx[k] + ax);
    gx[j] = clamp48(gx[j] - ax);
    gy[k] = clamp48(gy[k] + ay);
    gy[j] = clamp48(gy[j] - ay);
  endfunction

  function automatic void predict_gradients(in_t a, bit typed);
    longint e;
    out_t r;
    if (n_stored < NATOMS) begin
      xs[n_stored] = longint'(a.pos_x);
      ys[n_stored] = longint'(a.pos_y);
      n_stored++;
    end else begin
      sat_seen = 1'b1;
    end
    if (!a.final_atom) return;
    for (int k = 0; k < NATOMS; k++) begin
      gx[k] = 0;
      gy[k] = 0;
    end
    energy_sum = 0;
    for (int k = 1; k < n_stored; k++)
      for (int j = 0; j < k; j++)
        pair_force(k, j);
    e = clamp48(energy_sum * 4);
    for (int k = 0; k < n_stored; k++) begin
      gx[k] = clamp48(gx[k] * 4);
      gy[k] = clamp48(gy[k] * 4);
    end
    for (int k = 0; k < n_stored; k++) begin
      r.atom_index = k[2:0];
      r.grad_x = gx[k][47:0];
      r.grad_y = gy[k][47:0];
      r.run_end = (k + 1 == n_stored);
      r.energy = r.run_end ? e[47:0] : 48'd0;
      r.saturated = sat_seen;
      if (typed) begin
        r = '0;
        r.run_end = 1'b1;
      end
      gradient_q.push_back(r);
    end
    n_stored = 0;
    sat_seen = 1'b0;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (gradient_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_data.atom_index, -1);
      end else begin
        want = gradient_q.pop_front();
        if (out_data.atom_index !== want.atom_index)
          report_mismatch("atom_index", out_data.atom_index, want.atom_index);
        if (out_data.grad_x !== want.grad_x)
          report_mismatch("grad_x", out_data.grad_x, want.grad_x);
        if (out_data.grad_y !== want.grad_y)
          report_mismatch("grad_y", out_data.grad_y, want.grad_y);
        if (out_data.energy !== want.energy)
          report_mismatch("energy", out_data.energy, want.energy);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", out_data.saturated, want.saturated);
        if (out_data.run_end !== want.run_end)
          report_mismatch("run_end", out_data.run_end, want.run_end);
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off && stall == 0) stall = 600;
      if (stall > 0) begin
        stall--;
        if (stall == 0) hold_off = 1'b0;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic offer_atom(in_t a, bit typed);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_gradients(a, typed);
    items_sent++;
  endtask

  task automatic offer_set();
    int n;
    bit noisy;
    int base_x, base_y, spacing;
    in_t a;
    n = ($urandom_range(99) < 8) ? $urandom_range(NATOMS + 1, NATOMS + 2)
                                 : $urandom_range(1, NATOMS);
    noisy = ($urandom_range(99) < 20);
    base_x = $signed($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000;
    base_y = $signed($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000;
    spacing = $urandom_range(32'h00C0_0000, 32'h0200_0000);
    for (int i = 0; i < n; i++) begin
      if (noisy) begin
        a.pos_x = $urandom;
        a.pos_y = $urandom;
      end else begin
        a.pos_x = base_x + (i % 3) * spacing + $signed($urandom_range(32'h3F_FFFF)) - 32'sh20_0000;
        a.pos_y = base_y + (i / 3) * spacing + $signed($urandom_range(32'h3F_FFFF)) - 32'sh20_0000;
      end
      a.final_atom = (i == n - 1);
      offer_atom(a, 1'b0);
    end
  endtask

  initial begin
    directed_rows = '{
      '{'{PMAX, PMAX, 1'b1}, 1'b1},
      '{'{PMIN, PMIN, 1'b1}, 1'b1},
      '{'{32'd0, 32'd0, 1'b0}, 1'b0},
      '{'{32'd0, 32'd0, 1'b1}, 1'b0},
      '{'{32'd0, 32'd0, 1'b0}, 1'b0},
      '{'{ONE, 32'd0, 1'b1}, 1'b0},
      '{'{-ONE, ONE, 1'b0}, 1'b0},
      '{'{-ONE, 32'h0180_0000, 1'b1}, 1'b0},
      '{'{32'h0000_1000, 32'd0, 1'b0}, 1'b0},
      '{'{32'h0000_1400, 32'h0000_0400, 1'b1}, 1'b0},
      '{'{PMAX, PMAX, 1'b0}, 1'b0},
      '{'{PMIN, PMIN, 1'b1}, 1'b0},
      '{'{32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0},
      '{'{32'h0140_0000, 32'h0000_0000, 1'b0}, 1'b0},
      '{'{32'h0280_0000, 32'h0130_0000, 1'b0}, 1'b0},
      '{'{32'hFEC0_0000, 32'h0260_0000, 1'b0}, 1'b0},
      '{'{32'h0000_0000, 32'h0260_0000, 1'b1}, 1'b0}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 28;
    recv_idle = 63;
    foreach (directed_rows[i]) offer_atom(directed_rows[i].atom, directed_rows[i].typed);
    // excess atoms: ten offered, the last two dropped, the final one still closes the set
    for (int i = 0; i < NATOMS + 2; i++)
      offer_atom('{i * 32'h0150_0000, (i % 2) * 32'h0120_0000, i == NATOMS + 1}, 1'b0);
    while (items_sent < 130) offer_set();
    send_idle = 63;
    recv_idle = 28;
    while (items_sent < 240) offer_set();
    send_idle = 0;
    recv_idle = 0;
    hold_off = 1'b1;
    while (items_sent < 330) offer_set();
    in_valid <= 1'b0;
    while (gradient_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
